[hw/rtl/assert_macros.svh]
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define WLP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define WLP_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[hw/rtl/wlp_pkg.sv]
// types and constants of the weighted line position block
package wlp_pkg;

   localparam int NUM_LANES       = 8;
   localparam int LANE_W          = $clog2(NUM_LANES);
   localparam int READ_W          = 13;
   localparam int WEIGHT_W        = 16;
   localparam int MASK_W          = NUM_LANES;
   localparam int ERR_W           = 16;
   localparam int PROD_W          = WEIGHT_W + READ_W + 1;
   localparam int NUM_W           = 33;
   localparam int DEN_W           = 16;
   localparam int ABS_W           = NUM_W - 1;
   localparam int QUOT_BITS       = 17;
   localparam int CSR_IDX_W       = 4;
   localparam int CSR_DATA_W      = WEIGHT_W;
   localparam int NUM_SENSORS_DEF = 8;

   localparam logic [READ_W-1:0]      FULL_SCALE = READ_W'(4096);
   localparam logic signed [ERR_W:0]  ERR_MAX    = (ERR_W+1)'(32767);
   localparam logic signed [ERR_W:0]  ERR_MIN    = -(ERR_W+1)'(32768);

   // controller to datapath
   typedef struct packed {
      logic              load;
      logic              mul;
      logic              add;
      logic              div_init;
      logic              div_step;
      logic              finish;
      logic [LANE_W-1:0] lane;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic den_zero;
      logic out_free;
   } status_type;

endpackage

[hw/rtl/wlp_ifs.sv]
// request and response channel interfaces
interface wlp_req_if;
   import wlp_pkg::*;
   logic              valid;
   logic              ready;
   logic [READ_W-1:0] sensor_0;
   logic [READ_W-1:0] sensor_1;
   logic [READ_W-1:0] sensor_2;
   logic [READ_W-1:0] sensor_3;
   logic [READ_W-1:0] sensor_4;
   logic [READ_W-1:0] sensor_5;
   logic [READ_W-1:0] sensor_6;
   logic [READ_W-1:0] sensor_7;
   logic [MASK_W-1:0] invalid_mask;

   modport source (output valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4,
                   sensor_5, sensor_6, sensor_7, invalid_mask, input ready);
   modport sink   (input valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4,
                   sensor_5, sensor_6, sensor_7, invalid_mask, output ready);
endinterface

interface wlp_rsp_if;
   import wlp_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [ERR_W-1:0] line_error;
   logic                    fallback_used;

   modport source (output valid, line_error, fallback_used, input ready);
   modport sink   (input valid, line_error, fallback_used, output ready);
endinterface

[hw/rtl/wlp_datapath.sv]
// weight registers, multiply-accumulate, radix-2 divider and result register
module wlp_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [wlp_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [wlp_pkg::CSR_DATA_W-1:0]          csr_wdata,
   input  logic [wlp_pkg::READ_W-1:0]              sensor_in [wlp_pkg::NUM_LANES],
   input  logic [wlp_pkg::MASK_W-1:0]              mask_in,
   input  wlp_pkg::cmd_type                        cmd,
   output wlp_pkg::status_type                     status,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic signed [wlp_pkg::ERR_W-1:0]        out_line_error,
   output logic                                    out_fallback
);
   import wlp_pkg::*;

   logic signed [WEIGHT_W-1:0] weight_ff [NUM_LANES];
   logic [READ_W-1:0]          sensor_ff [NUM_LANES];
   logic [MASK_W-1:0]          mask_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [READ_W-1:0]          rdg_ff, rdg_in;
   logic signed [NUM_W-1:0]    num_ff;
   logic [DEN_W-1:0]           den_ff;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [QUOT_BITS-1:0]       sh_ff, sh_in;
   logic                       neg_ff;
   logic signed [ERR_W-1:0]    prev_ff, result_in;
   logic                       out_valid_ff;
   logic signed [ERR_W-1:0]    out_err_ff;
   logic                       out_fb_ff;

   logic [READ_W-1:0]          lane_rdg;
   logic                       lane_kept;
   logic [NUM_W-1:0]           num_neg;
   logic [ABS_W-1:0]           num_abs;
   logic [DEN_W:0]             trial;
   logic [DEN_W:0]             diff;
   logic signed [ERR_W+1:0]    quot_s;

   // lane product, zeroed for skipped readings
   always_comb begin
      lane_rdg  = sensor_ff[cmd.lane];
      lane_kept = !mask_ff[cmd.lane] && (lane_rdg <= FULL_SCALE);
      prod_in   = weight_ff[cmd.lane] * $signed({1'b0, lane_rdg});
      rdg_in    = lane_rdg;
      if (!lane_kept) begin
         prod_in = '0;
         rdg_in  = '0;
      end
   end

   // one restoring divide step
   always_comb begin
      num_neg = -num_ff;
      num_abs = num_ff[NUM_W-1] ? num_neg[ABS_W-1:0] : num_ff[ABS_W-1:0];
      trial   = {rem_ff, sh_ff[QUOT_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      if (trial >= {1'b0, den_ff}) begin
         rem_in = diff[DEN_W-1:0];
         sh_in  = {sh_ff[QUOT_BITS-2:0], 1'b1};
      end else begin
         rem_in = trial[DEN_W-1:0];
         sh_in  = {sh_ff[QUOT_BITS-2:0], 1'b0};
      end
   end

   // signed quotient, clamped; previous error when nothing contributed
   always_comb begin
      quot_s = neg_ff ? -$signed({1'b0, sh_ff}) : $signed({1'b0, sh_ff});
      if (den_ff == '0) begin
         result_in = prev_ff;
      end else if (quot_s > (ERR_W+2)'(ERR_MAX)) begin
         result_in = ERR_MAX[ERR_W-1:0];
      end else if (quot_s < (ERR_W+2)'(ERR_MIN)) begin
         result_in = ERR_MIN[ERR_W-1:0];
      end else begin
         result_in = quot_s[ERR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            weight_ff[i] <= '0;
         end
         prev_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_index < CSR_IDX_W'(NUM_LANES))) begin
            weight_ff[csr_index[LANE_W-1:0]] <= csr_wdata;
         end
         if (cmd.finish) begin
            prev_ff      <= result_in;
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sensor_ff <= sensor_in;
         mask_ff   <= mask_in;
         num_ff    <= '0;
         den_ff    <= '0;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         rdg_ff  <= rdg_in;
      end
      if (cmd.add) begin
         num_ff <= num_ff + NUM_W'(prod_ff);
         den_ff <= den_ff + DEN_W'(rdg_ff);
      end
      if (cmd.div_init) begin
         // quotient magnitude stays within QUOT_BITS, so the high dividend bits seed the remainder
         rem_ff <= DEN_W'(num_abs[ABS_W-1:QUOT_BITS]);
         sh_ff  <= num_abs[QUOT_BITS-1:0];
         neg_ff <= num_ff[NUM_W-1];
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         sh_ff  <= sh_in;
      end
      if (cmd.finish) begin
         out_err_ff <= result_in;
         out_fb_ff  <= (den_ff == '0);
      end
   end

   assign status.den_zero = (den_ff == '0);
   assign status.out_free = !out_valid_ff || out_ready;
   assign out_valid       = out_valid_ff;
   assign out_line_error  = out_err_ff;
   assign out_fallback    = out_fb_ff;

endmodule

[hw/rtl/wlp_controller.sv]
// sequencer for accumulate, divide and result hand-off
module wlp_controller #(
   parameter int NUM_SENSORS = wlp_pkg::NUM_SENSORS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wlp_pkg::status_type status,
   output wlp_pkg::cmd_type    cmd
);
   import wlp_pkg::*;

   localparam int CNT_W  = $clog2(NUM_SENSORS);
   localparam int STEP_W = $clog2(QUOT_BITS);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_ADD   = 6'b000100,
      ST_DINIT = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  lane_ff, lane_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in     = state_ff;
      lane_in      = lane_ff;
      step_in      = step_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.lane     = LANE_W'(lane_ff);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               lane_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            if (lane_ff == CNT_W'(NUM_SENSORS - 1)) begin
               state_in = ST_DINIT;
            end else begin
               lane_in  = lane_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = status.den_zero ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(QUOT_BITS - 1)) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lane_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         lane_ff  <= lane_in;
         step_ff  <= step_in;
      end
   end

endmodule

[hw/rtl/weighted_line_position.sv]
// top level of the weighted line position block
// Weighted-centroid line position. Each request is one frame of eight Q1.12
// reflectance readings (4096 = 1.0) plus an invalid mask; readings that are
// masked or above 4096 are skipped, as are lanes at or beyond NUM_SENSORS. The
// block returns sum(weight_i * reading_i) / sum(reading_i), truncated toward
// zero and clamped to 16 bits; when the sum of readings is zero it returns the
// previous result with fallback_used set. Weights are written through the csr
// port (index 0..7, higher indexes ignored); the user must write them only while
// the block is idle, which the block does not enforce. One request is handled at
// a time, stepped by one shared multiplier through the lanes and a radix-2
// divider that produces one of 17 quotient bits per cycle. A frame with no
// usable reading skips the divider. The result sits in an output register, so
// the next request is accepted while the previous response still waits to be
// taken.
module weighted_line_position #(
   parameter int NUM_SENSORS = wlp_pkg::NUM_SENSORS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   wlp_req_if.sink                         req_chan,
   wlp_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [wlp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wlp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wlp_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic [READ_W-1:0] sensors [NUM_LANES];
   logic              req_ready;

   // request fields gathered into a lane array for the datapath
   always_comb begin
      sensors[0] = req_chan.sensor_0;
      sensors[1] = req_chan.sensor_1;
      sensors[2] = req_chan.sensor_2;
      sensors[3] = req_chan.sensor_3;
      sensors[4] = req_chan.sensor_4;
      sensors[5] = req_chan.sensor_5;
      sensors[6] = req_chan.sensor_6;
      sensors[7] = req_chan.sensor_7;
   end

   // ready only in idle; the request is captured on acceptance
   assign req_chan.ready = req_ready;

   // sequencer: lane loop, divider steps, hand-off to the output register
   wlp_controller #(
      .NUM_SENSORS (NUM_SENSORS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // weights, accumulators, divider, previous error and response register
   wlp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .sensor_in      (sensors),
      .mask_in        (req_chan.invalid_mask),
      .cmd            (cmd),
      .status         (status),
      .out_valid      (rsp_chan.valid),
      .out_ready      (rsp_chan.ready),
      .out_line_error (rsp_chan.line_error),
      .out_fallback   (rsp_chan.fallback_used)
   );

endmodule

[hw/rtl/wlp_checker.sv]
// port-level checks of the weighted line position block and their bind
`include "assert_macros.svh"

module wlp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [wlp_pkg::ERR_W-1:0] rsp_line_error,
   input logic                             rsp_fallback_used
);
   import wlp_pkg::*;

   logic [1:0]              pend_ff, pend_in;
   logic signed [ERR_W-1:0] last_ff;
   logic                    req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff + 2'(req_acc) - 2'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         last_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         if (rsp_acc) begin
            last_ff <= rsp_line_error;
         end
      end
   end

   `WLP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_error) && $stable(rsp_fallback_used), "response changed while stalled")
   `WLP_ASSERT_NEVER(a_no_orphan, clock, reset, rsp_valid && (pend_ff == 2'd0), "response without a pending request")
   `WLP_ASSERT(a_pend_bound, clock, reset, req_acc |-> pend_ff <= 2'd1, "request accepted with two pending")
   `WLP_ASSERT(a_fallback_prev, clock, reset, rsp_valid && rsp_fallback_used |-> rsp_line_error == last_ff, "fallback does not repeat the previous error")

endmodule

bind weighted_line_position wlp_checker u_wlp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_line_error    (rsp_chan.line_error),
   .rsp_fallback_used (rsp_chan.fallback_used)
);

[sim/weighted_line_position_tb.sv]
// self-checking testbench of the weighted line position block
module weighted_line_position_tb;
   import wlp_pkg::*;

   // register map: weight i sits at index WEIGHT_BASE + i, higher indexes are unused
   localparam int WEIGHT_BASE     = 0;
   localparam int LAST_CSR_INDEX  = (1 << CSR_IDX_W) - 1;
   localparam int MAX_GAP         = 18;
   localparam int SETTLE_CYCLES   = 2 * NUM_SENSORS_DEF + 24;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int LONG_HOLD       = 400;

   typedef struct packed {
      logic [NUM_LANES-1:0][READ_W-1:0] reading;
      logic [MASK_W-1:0]                mask;
   } frame_type;

   typedef struct {
      logic signed [ERR_W-1:0] line_error;
      logic                    fallback_used;
   } position_type;

   typedef logic signed [WEIGHT_W-1:0] weight_set_type [NUM_LANES];

   // weight profiles, one per random phase
   typedef enum int {
      PROFILE_RANDOM,
      PROFILE_MAX,
      PROFILE_MIN,
      PROFILE_RAMP,
      PROFILE_SMALL,
      PROFILE_SPARSE,
      PROFILE_BURST,
      NUM_PROFILES
   } weight_profile_type;

   // predicts the centroid of each accepted frame and checks responses in order
   class position_scoreboard;
      weight_set_type          weight;
      logic signed [ERR_W-1:0] prev_line_error;
      position_type            expected_positions[$];
      int unsigned             mismatches;
      int unsigned             checked;
      int unsigned             fallbacks;

      function new();
         foreach (weight[i]) weight[i] = '0;
         prev_line_error = '0;
         mismatches      = 0;
         checked         = 0;
         fallbacks       = 0;
      endfunction

      function void set_weight(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         if (index < WEIGHT_BASE + NUM_LANES)
            weight[index - WEIGHT_BASE] = value;
      endfunction

      function void note_frame(frame_type f);
         longint       weighted_sum;
         longint       reading_sum;
         longint       quotient;
         position_type want;
         weighted_sum = 0;
         reading_sum  = 0;
         for (int i = 0; i < NUM_SENSORS_DEF; i++) begin
            if (f.mask[i] || f.reading[i] > FULL_SCALE)
               continue;
            weighted_sum += longint'(weight[i]) * longint'(f.reading[i]);
            reading_sum  += longint'(f.reading[i]);
         end
         if (reading_sum == 0) begin
            want.line_error    = prev_line_error;
            want.fallback_used = 1'b1;
            fallbacks++;
         end else begin
            quotient = weighted_sum / reading_sum;
            if (quotient > 32767)
               quotient = 32767;
            if (quotient < -32768)
               quotient = -32768;
            want.line_error    = ERR_W'(quotient);
            want.fallback_used = 1'b0;
         end
         prev_line_error = want.line_error;
         expected_positions.push_back(want);
      endfunction

      task report(string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $time, what);
      endtask

      task check_result(logic signed [ERR_W-1:0] line_error, logic fallback_used);
         position_type want;
         if (expected_positions.size() == 0) begin
            report($sformatf("response %0d/%0b with no request pending",
                             line_error, fallback_used));
            return;
         end
         want = expected_positions.pop_front();
         checked++;
         if (line_error !== want.line_error)
            report($sformatf("response %0d line_error %0d, expected %0d",
                             checked, line_error, want.line_error));
         if (fallback_used !== want.fallback_used)
            report($sformatf("response %0d fallback_used %0b, expected %0b",
                             checked, fallback_used, want.fallback_used));
      endtask
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wlp_req_if req_if ();
   wlp_rsp_if rsp_if ();

   position_scoreboard sb;

   // both sides skip their idle cycles while set
   bit          no_gaps;
   // a nonzero value makes the response side hold off this many cycles once
   int unsigned hold_cycles;
   int unsigned csr_writes;
   int unsigned stray_writes;
   int unsigned weight_settings;

   weighted_line_position u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // slowest correct run is ~1450 requests plus the long holds and settle time;
   // this timeout ends the run well after that
   initial begin
      #1_200_000;
      $display("Mismatches found");
      $finish;
   end

   // one register write per clock; the caller lowers csr_we afterwards
   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_weight(index, value);
      csr_writes++;
   endtask

   // all eight weights plus one write to an unused index, which must be ignored
   task automatic load_weights(input weight_set_type w);
      for (int i = 0; i < NUM_LANES; i++)
         csr_write(CSR_IDX_W'(WEIGHT_BASE + i), w[i]);
      csr_write(CSR_IDX_W'($urandom_range(WEIGHT_BASE + NUM_LANES, LAST_CSR_INDEX)),
                CSR_DATA_W'($urandom));
      stray_writes++;
      weight_settings++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // drop the request line, then wait until every response is back and the
   // datapath has settled
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.expected_positions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // offer one request after a random gap; valid stays high across back-to-back requests
   task automatic send_frame(input frame_type f);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.sensor_0     <= f.reading[0];
      req_if.sensor_1     <= f.reading[1];
      req_if.sensor_2     <= f.reading[2];
      req_if.sensor_3     <= f.reading[3];
      req_if.sensor_4     <= f.reading[4];
      req_if.sensor_5     <= f.reading[5];
      req_if.sensor_6     <= f.reading[6];
      req_if.sensor_7     <= f.reading[7];
      req_if.invalid_mask <= f.mask;
      do @(posedge clock); while (!req_if.ready);
      sb.note_frame(f);
   endtask

   // response side: random stall before each response, or one long hold when asked
   task automatic take_responses();
      int unsigned stall;
      forever begin
         if (hold_cycles != 0) begin
            stall       = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         sb.check_result(rsp_if.line_error, rsp_if.fallback_used);
      end
   endtask

   function automatic frame_type uniform_frame(logic [READ_W-1:0] value,
                                               logic [MASK_W-1:0] mask);
      frame_type f;
      for (int i = 0; i < NUM_LANES; i++)
         f.reading[i] = value;
      f.mask = mask;
      return f;
   endfunction

   // mostly in-range readings, with zeros, full scale, over-range values and masks mixed in
   function automatic frame_type random_frame();
      frame_type   f;
      int unsigned pick;
      for (int i = 0; i < NUM_LANES; i++) begin
         pick = $urandom_range(0, 19);
         if (pick < 12)
            f.reading[i] = READ_W'($urandom_range(0, 4096));
         else if (pick < 14)
            f.reading[i] = '0;
         else if (pick < 16)
            f.reading[i] = FULL_SCALE;
         else
            f.reading[i] = READ_W'($urandom_range(4097, (1 << READ_W) - 1));
      end
      pick = $urandom_range(0, 9);
      if (pick < 5)
         f.mask = '0;
      else if (pick < 9)
         f.mask = MASK_W'($urandom);
      else
         f.mask = '1;
      return f;
   endfunction

   // typical line-sensor layout: evenly spaced positions around the center
   function automatic weight_set_type ramp_weights();
      weight_set_type w;
      for (int i = 0; i < NUM_LANES; i++)
         w[i] = WEIGHT_W'(-3500 + 1000 * i);
      return w;
   endfunction

   initial begin
      frame_type          f;
      weight_set_type     w;
      weight_profile_type profile;

      // every input known from time zero
      req_if.valid        = 1'b0;
      req_if.sensor_0     = '0;
      req_if.sensor_1     = '0;
      req_if.sensor_2     = '0;
      req_if.sensor_3     = '0;
      req_if.sensor_4     = '0;
      req_if.sensor_5     = '0;
      req_if.sensor_6     = '0;
      req_if.sensor_7     = '0;
      req_if.invalid_mask = '0;
      rsp_if.ready        = 1'b0;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      no_gaps             = 1'b0;
      hold_cycles         = 0;
      csr_writes          = 0;
      stray_writes        = 0;
      weight_settings     = 0;
      sb = new();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      fork
         take_responses();
      join_none

      // reset weights are zero: an empty frame falls back to the reset error,
      // a full frame gives zero
      send_frame(uniform_frame('0, '0));
      send_frame(uniform_frame(FULL_SCALE, '0));
      wait_drained();

      // directed requests on the evenly spaced layout
      load_weights(ramp_weights());
      send_frame(uniform_frame(FULL_SCALE, '0));
      // each lane alone returns its own weight
      for (int i = 0; i < NUM_LANES; i++) begin
         f = uniform_frame('0, '0);
         f.reading[i] = FULL_SCALE;
         send_frame(f);
      end
      // smallest nonzero reading on the outer lane
      f = uniform_frame('0, '0);
      f.reading[7] = READ_W'(1);
      send_frame(f);
      // readings just above one and at the top of the field are skipped: fallback
      send_frame(uniform_frame(READ_W'(4097), '0));
      send_frame(uniform_frame('1, '0));
      // all lanes masked, then all readings zero: fallback again
      send_frame(uniform_frame(FULL_SCALE, '1));
      send_frame(uniform_frame('0, '0));
      // negative quotient with a remainder, truncated toward zero
      f = uniform_frame('0, '0);
      f.reading[0] = READ_W'(1);
      f.reading[1] = READ_W'(2);
      send_frame(f);
      // lower half masked leaves the upper lanes
      send_frame(uniform_frame(FULL_SCALE, MASK_W'(8'h0F)));
      wait_drained();

      // extreme weights: most positive everywhere but lane 0 at most negative
      for (int i = 0; i < NUM_LANES; i++)
         w[i] = 16'sh7FFF;
      w[0] = 16'sh8000;
      load_weights(w);
      send_frame(uniform_frame(FULL_SCALE, '0));
      f = uniform_frame('0, '0);
      f.reading[0] = FULL_SCALE;
      send_frame(f);
      f = uniform_frame('0, '0);
      f.reading[1] = FULL_SCALE;
      send_frame(f);
      f.reading[0] = FULL_SCALE;
      f.reading[1] = READ_W'(1);
      send_frame(f);
      wait_drained();

      // random phases, one weight profile each
      for (int phase = 0; phase < NUM_PROFILES; phase++) begin
         profile = weight_profile_type'(phase);
         for (int i = 0; i < NUM_LANES; i++) begin
            case (profile)
               PROFILE_MAX:    w[i] = 16'sh7FFF;
               PROFILE_MIN:    w[i] = 16'sh8000;
               PROFILE_RAMP:   w = ramp_weights();
               PROFILE_SMALL:  w[i] = WEIGHT_W'($urandom_range(0, 200) - 100);
               PROFILE_SPARSE: w[i] = ($urandom_range(0, 2) == 0) ? '0 : WEIGHT_W'($urandom);
               default:        w[i] = WEIGHT_W'($urandom);
            endcase
         end
         load_weights(w);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // stretches without idle cycles on either side
            if (n % 50 == 0)
               no_gaps = (profile == PROFILE_BURST) || ($urandom_range(0, 3) == 0);
            // response side holds off while requests keep coming, so the block backs up
            if (profile == PROFILE_RAMP && (n == 40 || n == 140))
               hold_cycles = LONG_HOLD;
            send_frame(random_frame());
         end
         @(negedge clock);
         req_if.valid <= 1'b0;
         no_gaps = 1'b0;
         wait_drained();
      end

      $display("checked %0d responses, %0d of them fallbacks with no usable reading",
               sb.checked, sb.fallbacks);
      $display("went through %0d weight settings in %0d register writes, %0d to unused indexes",
               weight_settings, csr_writes, stray_writes);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[weighted_line_position.f]
+incdir+hw/rtl
hw/rtl/wlp_pkg.sv
hw/rtl/wlp_ifs.sv
hw/rtl/wlp_datapath.sv
hw/rtl/wlp_controller.sv
hw/rtl/weighted_line_position.sv
hw/rtl/wlp_checker.sv
sim/weighted_line_position_tb.sv
